// ===== rtl/core/lssd_pkg.sv =====
`timescale 1ns / 1ps

package lssd_pkg;

    // stream payload widths
    localparam int IN_DATA_W  = 48;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 32;

    // config port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 26;

    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_SLOPE    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_SLOPE    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_DUTY_CMD_LOW = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_DUTY_CMD_MID = 3'd4;

    localparam logic [11:0] RST_FRAME_WIDTH  = 12'd320;
    localparam logic [25:0] RST_MAX_SLOPE    = 26'd262144;
    localparam logic [25:0] RST_MIN_SLOPE    = 26'd6554;
    localparam logic [11:0] RST_DUTY_CMD_LOW = 12'd1250;
    localparam logic [11:0] RST_DUTY_CMD_MID = 12'd1150;

    // slope / intercept formats
    localparam int SLOPE_W = 27;
    localparam int MAG_W   = 26;
    localparam int ICPT_W  = 40;

    localparam logic [MAG_W-1:0]          SLOPE_LIM = {MAG_W{1'b1}};
    localparam logic signed [ICPT_W-1:0]  ICPT_MAX  = {1'b0, {(ICPT_W-1){1'b1}}};
    localparam logic signed [ICPT_W-1:0]  ICPT_MIN  = {1'b1, {(ICPT_W-1){1'b0}}};

    localparam logic [3:0] MOTOR_DIVISOR = 4'd10;

    // x / 10 as (x * 52429) >> 19, exact for x below 87389 (all 16-bit x)
    localparam logic [31:0] MOTOR_RECIP       = 32'd52429;
    localparam int          MOTOR_RECIP_SHIFT = 19;

    // steering zones
    localparam logic [2:0] ZONE_HOLD         = 3'd0;
    localparam logic [2:0] ZONE_LEFT         = 3'd1;
    localparam logic [2:0] ZONE_LITTLE_LEFT  = 3'd2;
    localparam logic [2:0] ZONE_LEFT_CORR    = 3'd3;
    localparam logic [2:0] ZONE_RIGHT        = 3'd4;
    localparam logic [2:0] ZONE_LITTLE_RIGHT = 3'd5;
    localparam logic [2:0] ZONE_RIGHT_CORR   = 3'd6;
    localparam logic [2:0] ZONE_FORWARD      = 3'd7;

    localparam logic [11:0] SERVO_LEFT         = 12'd160;
    localparam logic [11:0] SERVO_LITTLE_LEFT  = 12'd200;
    localparam logic [11:0] SERVO_LEFT_CORR    = 12'd220;
    localparam logic [11:0] SERVO_FORWARD      = 12'd240;
    localparam logic [11:0] SERVO_RIGHT_CORR   = 12'd260;
    localparam logic [11:0] SERVO_LITTLE_RIGHT = 12'd280;
    localparam logic [11:0] SERVO_RIGHT        = 12'd320;

    // motor factors in tenths
    localparam logic [3:0] FACTOR_HARD = 4'd14;
    localparam logic [3:0] FACTOR_SOFT = 4'd13;
    localparam logic [3:0] FACTOR_CORR = 4'd11;
    localparam logic [3:0] FACTOR_ONE  = 4'd10;

    // zone border multipliers, sixteenths of frame width
    localparam logic [3:0] BORDER_POS_OUTER = 4'd15;
    localparam logic [3:0] BORDER_POS_HARD  = 4'd7;
    localparam logic [3:0] BORDER_POS_SOFT  = 4'd11;
    localparam logic [3:0] BORDER_NEG_OUTER = 4'd1;
    localparam logic [3:0] BORDER_NEG_HARD  = 4'd9;
    localparam logic [3:0] BORDER_NEG_SOFT  = 4'd5;

    typedef struct packed {
        logic       load_in;
        logic       div_seg;
        logic       mot_load;
        logic       slope_load;
        logic       mul_seg;
        logic       mul_tst;
        logic       seg_upd;
        logic       t_load;
        logic [3:0] k;
        logic [2:0] zone;
        logic       out_load;
    } lssd_cmd_t;

    typedef struct packed {
        logic has_seg;
        logic last;
        logic dx_zero;
        logic div_done;
        logic div_busy;
        logic in_range;
        logic s_pos;
        logic ix_lt;
        logic out_free;
    } lssd_sts_t;

    function automatic logic [11:0] servo_of_zone(input logic [2:0] zone);
        logic [11:0] v;
        unique case (zone)
            ZONE_LEFT:         v = SERVO_LEFT;
            ZONE_LITTLE_LEFT:  v = SERVO_LITTLE_LEFT;
            ZONE_LEFT_CORR:    v = SERVO_LEFT_CORR;
            ZONE_RIGHT:        v = SERVO_RIGHT;
            ZONE_LITTLE_RIGHT: v = SERVO_LITTLE_RIGHT;
            ZONE_RIGHT_CORR:   v = SERVO_RIGHT_CORR;
            ZONE_FORWARD:      v = SERVO_FORWARD;
            default:           v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [3:0] factor_of_zone(input logic [2:0] zone);
        logic [3:0] v;
        unique case (zone)
            ZONE_LEFT, ZONE_RIGHT:               v = FACTOR_HARD;
            ZONE_LITTLE_LEFT, ZONE_LITTLE_RIGHT: v = FACTOR_SOFT;
            ZONE_LEFT_CORR, ZONE_RIGHT_CORR:     v = FACTOR_CORR;
            ZONE_FORWARD:                        v = FACTOR_SOFT;
            default:                             v = FACTOR_ONE;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/lssd_div.sv =====
`timescale 1ns / 1ps

// radix-2 restoring divider, one quotient bit per cycle
module lssd_div #(
    parameter int NUM_W = 28,
    parameter int DEN_W = 12
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_diff;

    assign rem_sh   = {rem_reg, num_reg[NUM_W-1]};
    assign rem_diff = rem_sh - {1'b0, den_reg};

    always_comb begin
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        done_next = 1'b0;
        if (start) begin
            cnt_next = CNT_W'(NUM_W);
            num_next = num;
            rem_next = '0;
            den_next = den;
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - 1'b1;
            if (!rem_diff[DEN_W]) begin
                rem_next = rem_diff[DEN_W-1:0];
                num_next = {num_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next = rem_sh[DEN_W-1:0];
                num_next = {num_reg[NUM_W-2:0], 1'b0};
            end
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy = (cnt_reg != '0);
    assign done = done_reg;
    assign quot = num_reg;

endmodule

// ===== rtl/core/lssd_datapath.sv =====
`timescale 1ns / 1ps

module lssd_datapath
    import lssd_pkg::*;
#(
    parameter int COORD_BITS      = 12,
    parameter int SLOPE_FRAC_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [IN_USER_W-1:0]  s_tuser,
    input  logic                  s_tlast,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  lssd_cmd_t             cmd,
    output lssd_sts_t             sts,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready
);

    localparam int NUM_W = COORD_BITS + SLOPE_FRAC_BITS;
    localparam int DEN_W = COORD_BITS;
    localparam int MB_W  = (COORD_BITS > 12) ? COORD_BITS : 12;
    localparam int PW    = SLOPE_W + MB_W + 1;
    localparam int BW    = ((NUM_W > PW) ? NUM_W : PW) + 2;
    localparam int CW    = (PW > ICPT_W + 1) ? PW : ICPT_W + 1;
    localparam int QW    = (NUM_W > MAG_W) ? NUM_W : MAG_W;

    // config
    logic [11:0] frame_width_reg;
    logic [25:0] max_slope_reg;
    logic [25:0] min_slope_reg;
    logic [11:0] duty_low_reg;
    logic [11:0] duty_mid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg <= RST_FRAME_WIDTH;
            max_slope_reg   <= RST_MAX_SLOPE;
            min_slope_reg   <= RST_MIN_SLOPE;
            duty_low_reg    <= RST_DUTY_CMD_LOW;
            duty_mid_reg    <= RST_DUTY_CMD_MID;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_FRAME_WIDTH:  frame_width_reg <= cfg_wdata[11:0];
                REG_MAX_SLOPE:    max_slope_reg   <= cfg_wdata;
                REG_MIN_SLOPE:    min_slope_reg   <= cfg_wdata;
                REG_DUTY_CMD_LOW: duty_low_reg    <= cfg_wdata[11:0];
                REG_DUTY_CMD_MID: duty_mid_reg    <= cfg_wdata[11:0];
                default: ;
            endcase
        end
    end

    // request capture
    logic [COORD_BITS-1:0] x1_in, y1_in, x2_in, y2_in;
    logic signed [COORD_BITS:0] dx_in, dy_in, dx_abs, dy_abs;

    assign x1_in  = COORD_BITS'(s_tdata[11:0]);
    assign y1_in  = COORD_BITS'(s_tdata[23:12]);
    assign x2_in  = COORD_BITS'(s_tdata[35:24]);
    assign y2_in  = COORD_BITS'(s_tdata[47:36]);
    assign dx_in  = signed'({1'b0, x2_in}) - signed'({1'b0, x1_in});
    assign dy_in  = signed'({1'b0, y2_in}) - signed'({1'b0, y1_in});
    assign dx_abs = dx_in[COORD_BITS] ? -dx_in : dx_in;
    assign dy_abs = dy_in[COORD_BITS] ? -dy_in : dy_in;

    logic [COORD_BITS-1:0] x1_reg, y1_reg, dx_mag_reg, dy_mag_reg;
    logic                  dx_neg_reg, dy_neg_reg, dx_zero_reg;
    logic                  has_seg_reg, last_reg;
    logic [11:0]           base_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            has_seg_reg <= 1'b0;
            last_reg    <= 1'b0;
        end else if (cmd.load_in) begin
            has_seg_reg <= s_tuser[0];
            last_reg    <= s_tlast;
        end
        if (cmd.load_in) begin
            x1_reg      <= x1_in;
            y1_reg      <= y1_in;
            dx_mag_reg  <= dx_abs[COORD_BITS-1:0];
            dy_mag_reg  <= dy_abs[COORD_BITS-1:0];
            dx_neg_reg  <= dx_in[COORD_BITS];
            dy_neg_reg  <= dy_in[COORD_BITS];
            dx_zero_reg <= (dx_in == '0);
            base_reg    <= s_tuser[1] ? 12'd0 : (s_tuser[2] ? duty_mid_reg : duty_low_reg);
        end
    end

    // slope divider: |dy| * 2^F / |dx|
    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic             div_busy, div_done;
    logic [NUM_W-1:0] div_quot;

    assign div_num = {dy_mag_reg, {SLOPE_FRAC_BITS{1'b0}}};
    assign div_den = dx_mag_reg;

    lssd_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_seg),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .done    (div_done),
        .quot    (div_quot)
    );

    // motor duty: base * factor, then / 10 by reciprocal multiply at output load
    logic [15:0] mot_num;
    logic [15:0] mot_prod_reg;

    assign mot_num = 16'(base_reg) * 16'(factor_of_zone(cmd.zone));

    always_ff @(posedge aclk) begin
        if (cmd.mot_load) begin
            mot_prod_reg <= mot_num;
        end
    end

    // slope from quotient, saturated
    logic [QW-1:0]            q_ext;
    logic [MAG_W-1:0]         q_sat;
    logic signed [SLOPE_W-1:0] q_signed, s_new;
    logic signed [SLOPE_W-1:0] s_reg;

    assign q_ext    = QW'(div_quot);
    assign q_sat    = (q_ext > QW'(SLOPE_LIM)) ? SLOPE_LIM : q_ext[MAG_W-1:0];
    assign q_signed = signed'({1'b0, q_sat});

    always_comb begin
        if (dx_zero_reg) begin
            s_new = dy_neg_reg ? -signed'({1'b0, SLOPE_LIM}) : signed'({1'b0, SLOPE_LIM});
        end else begin
            s_new = (dx_neg_reg ^ dy_neg_reg) ? -q_signed : q_signed;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.slope_load) begin
            s_reg <= s_new;
        end
    end

    // shared multiplier: slope * x1 or slope * border
    logic signed [SLOPE_W-1:0] best_slope_reg;
    logic signed [ICPT_W-1:0]  best_icpt_reg;
    logic [11:0]               t_reg;
    logic signed [SLOPE_W-1:0] mul_a;
    logic [MB_W-1:0]           mul_b;
    logic signed [PW-1:0]      mul_p, prod_reg;

    assign mul_a = cmd.mul_tst ? best_slope_reg : s_reg;
    assign mul_b = cmd.mul_tst ? MB_W'(t_reg) : MB_W'(x1_reg);
    assign mul_p = PW'(mul_a) * PW'(signed'({1'b0, mul_b}));

    always_ff @(posedge aclk) begin
        if (cmd.mul_seg || cmd.mul_tst) begin
            prod_reg <= mul_p;
        end
        if (cmd.t_load) begin
            t_reg <= 12'((16'(frame_width_reg) * 16'(cmd.k)) >> 4);
        end
    end

    // intercept and running minimum
    logic signed [BW-1:0]     ysh, bdiff;
    logic signed [ICPT_W-1:0] b_sat;
    logic [SLOPE_W-1:0]       s_abs, best_abs;
    logic [MAG_W-1:0]         s_mag, best_mag;

    assign ysh   = signed'(BW'({y1_reg, {SLOPE_FRAC_BITS{1'b0}}}));
    assign bdiff = ysh - BW'(prod_reg);

    always_comb begin
        if (bdiff > BW'(ICPT_MAX)) begin
            b_sat = ICPT_MAX;
        end else if (bdiff < BW'(ICPT_MIN)) begin
            b_sat = ICPT_MIN;
        end else begin
            b_sat = bdiff[ICPT_W-1:0];
        end
    end

    assign s_abs    = s_reg[SLOPE_W-1] ? -s_reg : s_reg;
    assign s_mag    = s_abs[MAG_W-1:0];
    assign best_abs = best_slope_reg[SLOPE_W-1] ? -best_slope_reg : best_slope_reg;
    assign best_mag = best_abs[MAG_W-1:0];

    logic        frame_first_reg;
    logic [11:0] held_servo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_slope_reg  <= '0;
            best_icpt_reg   <= '0;
            frame_first_reg <= 1'b1;
            held_servo_reg  <= '0;
        end else begin
            if (cmd.seg_upd) begin
                if (frame_first_reg || (s_mag < best_mag)) begin
                    best_slope_reg <= s_reg;
                    best_icpt_reg  <= b_sat;
                end
                frame_first_reg <= 1'b0;
            end
            if (cmd.out_load) begin
                frame_first_reg <= 1'b1;
                if (cmd.zone != ZONE_HOLD) begin
                    held_servo_reg <= servo_of_zone(cmd.zone);
                end
            end
        end
    end

    // x intercept test: -b < t*s covers both slope signs
    logic signed [CW-1:0] neg_b, prod_c;

    assign neg_b = -CW'(best_icpt_reg);
    assign prod_c = CW'(prod_reg);

    // output register
    logic        out_valid_reg;
    logic [11:0] servo_reg;
    logic [12:0] motor_reg;
    logic [2:0]  zone_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            zone_reg <= cmd.zone;
            if (cmd.zone == ZONE_HOLD) begin
                servo_reg <= held_servo_reg;
                motor_reg <= 13'(base_reg);
            end else begin
                servo_reg <= servo_of_zone(cmd.zone);
                motor_reg <= 13'((32'(mot_prod_reg) * MOTOR_RECIP) >> MOTOR_RECIP_SHIFT);
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, zone_reg, motor_reg, servo_reg};

    assign sts.has_seg  = has_seg_reg;
    assign sts.last     = last_reg;
    assign sts.dx_zero  = dx_zero_reg;
    assign sts.div_done = div_done;
    assign sts.div_busy = div_busy;
    assign sts.in_range = (best_mag < max_slope_reg) && (best_mag > min_slope_reg);
    assign sts.s_pos    = !best_slope_reg[SLOPE_W-1];
    assign sts.ix_lt    = (neg_b < prod_c);
    assign sts.out_free = !out_valid_reg || m_tready;

    a_out_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!out_valid_reg || m_tready))
        else $error("result loaded over a pending result");

endmodule

// ===== rtl/core/lssd_ctrl.sv =====
`timescale 1ns / 1ps

module lssd_ctrl
    import lssd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  lssd_sts_t sts,
    output lssd_cmd_t cmd
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_DISP    = 4'd1;
    localparam logic [3:0] ST_SEG_DIV = 4'd2;
    localparam logic [3:0] ST_SLOPE   = 4'd3;
    localparam logic [3:0] ST_SEG_MUL = 4'd4;
    localparam logic [3:0] ST_SEG_UPD = 4'd5;
    localparam logic [3:0] ST_DEC     = 4'd6;
    localparam logic [3:0] ST_TST_T   = 4'd7;
    localparam logic [3:0] ST_TST_P   = 4'd8;
    localparam logic [3:0] ST_TST_C   = 4'd9;
    localparam logic [3:0] ST_MOT     = 4'd10;
    localparam logic [3:0] ST_OUT     = 4'd11;

    localparam logic [1:0] TST_OUTER = 2'd0;
    localparam logic [1:0] TST_HARD  = 2'd1;
    localparam logic [1:0] TST_SOFT  = 2'd2;

    logic [3:0] state_reg, state_next;
    logic [1:0] idx_reg, idx_next;
    logic [2:0] zone_reg, zone_next;
    logic [3:0] k_sel;

    always_comb begin
        unique case (idx_reg)
            TST_OUTER: k_sel = sts.s_pos ? BORDER_POS_OUTER : BORDER_NEG_OUTER;
            TST_HARD:  k_sel = sts.s_pos ? BORDER_POS_HARD  : BORDER_NEG_HARD;
            default:   k_sel = sts.s_pos ? BORDER_POS_SOFT  : BORDER_NEG_SOFT;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        zone_next  = zone_reg;
        cmd        = '0;
        cmd.zone   = zone_reg;
        cmd.k      = k_sel;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DISP;
                end
            end
            ST_DISP: begin
                if (sts.has_seg) begin
                    if (sts.dx_zero) begin
                        state_next = ST_SLOPE;
                    end else begin
                        cmd.div_seg = 1'b1;
                        state_next  = ST_SEG_DIV;
                    end
                end else if (sts.last) begin
                    state_next = ST_DEC;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_SEG_DIV: begin
                if (sts.div_done) begin
                    state_next = ST_SLOPE;
                end
            end
            ST_SLOPE: begin
                cmd.slope_load = 1'b1;
                state_next     = ST_SEG_MUL;
            end
            ST_SEG_MUL: begin
                cmd.mul_seg = 1'b1;
                state_next  = ST_SEG_UPD;
            end
            ST_SEG_UPD: begin
                cmd.seg_upd = 1'b1;
                state_next  = sts.last ? ST_DEC : ST_IDLE;
            end
            ST_DEC: begin
                idx_next = TST_OUTER;
                if (sts.in_range) begin
                    state_next = ST_TST_T;
                end else begin
                    zone_next  = ZONE_HOLD;
                    state_next = ST_OUT;
                end
            end
            ST_TST_T: begin
                cmd.t_load = 1'b1;
                state_next = ST_TST_P;
            end
            ST_TST_P: begin
                cmd.mul_tst = 1'b1;
                state_next  = ST_TST_C;
            end
            ST_TST_C: begin
                unique case (idx_reg)
                    TST_OUTER: begin
                        if (sts.ix_lt) begin
                            idx_next   = TST_HARD;
                            state_next = ST_TST_T;
                        end else begin
                            zone_next  = ZONE_FORWARD;
                            state_next = ST_MOT;
                        end
                    end
                    TST_HARD: begin
                        if (sts.ix_lt) begin
                            zone_next  = sts.s_pos ? ZONE_LEFT : ZONE_RIGHT;
                            state_next = ST_MOT;
                        end else begin
                            idx_next   = TST_SOFT;
                            state_next = ST_TST_T;
                        end
                    end
                    default: begin
                        if (sts.ix_lt) begin
                            zone_next = sts.s_pos ? ZONE_LITTLE_LEFT : ZONE_LITTLE_RIGHT;
                        end else begin
                            zone_next = sts.s_pos ? ZONE_LEFT_CORR : ZONE_RIGHT_CORR;
                        end
                        state_next = ST_MOT;
                    end
                endcase
            end
            ST_MOT: begin
                cmd.mot_load = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= TST_OUTER;
            zone_reg  <= ZONE_HOLD;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            zone_reg  <= zone_next;
        end
    end

    a_done_when_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.div_done |-> (state_reg == ST_SEG_DIV))
        else $error("divider finished outside a wait state");

    a_cmp_after_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TST_C) |-> ($past(state_reg) == ST_TST_P))
        else $error("border compare without fresh product");

    a_ready_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !sts.div_busy)
        else $error("request taken while divider busy");

endmodule

// ===== rtl/core/lane_segment_steering_decider.sv =====
// Sequence: a segment request passes the divider, slope load, intercept multiply and
//   minimum update before the next accept; a vertical one skips the divider.
// Throughput: one request at a time, set by the radix-2 slope divider (one bit per cycle);
//   a result not yet taken stalls only the next frame end.
// Reset: aresetn synchronous active low; config to defaults, best slope/intercept and
//   held servo zero, next segment starts a frame, no result pending.
`timescale 1ns / 1ps

module lane_segment_steering_decider
    import lssd_pkg::*;
#(
    parameter int COORD_BITS      = 12,
    parameter int SLOPE_FRAC_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // segment requests
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // start_x, start_y, end_x, end_y
    input  logic [IN_USER_W-1:0]  s_tuser,   // has_segment, command_bit_a, command_bit_b
    input  logic                  s_tlast,   // frame_last
    // steering results
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // servo_pulse, motor_duty, steer_zone, pad
    // register writes
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    lssd_cmd_t cmd;
    lssd_sts_t sts;

    // Sequencer: take request, divide for slope, multiply for intercept, update the
    // running minimum; on frame end hold the servo if out of range, else test borders
    // with the shared multiplier and scale the motor duty by a reciprocal multiply.
    lssd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Arithmetic, stored state, config registers and the output register.
    // The output register lets a new request start while a result waits.
    lssd_datapath #(
        .COORD_BITS      (COORD_BITS),
        .SLOPE_FRAC_BITS (SLOPE_FRAC_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready)
    );

endmodule

// ===== sim/tb_lane_segment_steering_decider.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the lane segment steering decider.
// Segment requests go in on the s_ stream, one steering result per frame end comes
// back on the m_ stream. A local model of the decider tracks the kept segment and
// the held servo, and queues one expected result per frame-end request.
module tb_lane_segment_steering_decider;
    import lssd_pkg::*;

    localparam int     FRAC_BITS    = 16;
    localparam longint ONE_Q        = 64'sd1 << FRAC_BITS;
    localparam longint SLOPE_SAT    = 64'sd67108863;      // 2^26-1
    localparam longint ICPT_SAT     = 64'sd549755813887;  // 2^39-1
    localparam int     DRAIN_CYCLES = 120;     // well past worst segment + frame-end latency
    localparam int     HOLD_CYCLES  = 600;     // long receiver hold-off
    localparam int     CYCLE_LIMIT  = 1000000;

    // one segment request as the block sees it
    typedef struct {
        logic        has_seg;
        logic [11:0] start_x;
        logic [11:0] start_y;
        logic [11:0] end_x;
        logic [11:0] end_y;
        logic        last;
        logic        cmd_a;
        logic        cmd_b;
    } seg_req_t;

    typedef struct {
        logic [11:0] servo;
        logic [12:0] motor;
        logic [2:0]  zone;
    } steer_res_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;   // start_x, start_y, end_x, end_y
    logic [IN_USER_W-1:0]  s_tuser;   // has_segment, command_bit_a, command_bit_b
    logic                  s_tlast;   // frame_last
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;   // servo_pulse, motor_duty, steer_zone, pad
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    lane_segment_steering_decider dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // model copy of the registers
    logic [11:0] cfg_width;
    logic [25:0] cfg_max_slope;
    logic [25:0] cfg_min_slope;
    logic [11:0] cfg_duty_low;
    logic [11:0] cfg_duty_mid;

    // model copy of the decider state
    longint      kept_slope;
    longint      kept_icpt;
    bit          new_frame;
    logic [11:0] last_servo;

    steer_res_t  steer_expect_q[$];
    steer_res_t  exp_res;
    int          errors;
    int          items_sent;
    int          cycle_count;

    // sender burst shaping
    int          burst_left;
    int          gap_len;

    // receiver stall pattern; hold_req asks for one long hold-off
    bit          hold_req;
    int          hold_left;
    int          pattern_left;
    int          stall_pct;

    // ---------------------------------------------------------------
    // Model helpers
    // ---------------------------------------------------------------
    function automatic longint mag_of(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint border_at(input longint w, input logic [3:0] k);
        longint kk;
        kk = k;
        return w * kk / 16;
    endfunction

    // exact tests of x = -b/s against border t, s nonzero
    function automatic bit x_left_of(input longint b, input longint s, input longint t);
        return (s > 0) ? (-b < t * s) : (-b > t * s);
    endfunction

    function automatic bit x_right_of(input longint b, input longint s, input longint t);
        return (s > 0) ? (-b > t * s) : (-b < t * s);
    endfunction

    // Running-minimum update for a segment, then the steering decision on frame end.
    function automatic void predict_steering(input seg_req_t r);
        longint x1, y1, x2, y2, dx, dy, s, b, w, mag, base, mul, div;
        steer_res_t res;
        if (r.has_seg) begin
            x1 = r.start_x;
            y1 = r.start_y;
            x2 = r.end_x;
            y2 = r.end_y;
            dx = x2 - x1;
            dy = y2 - y1;
            if (dx == 0) begin
                // vertical: saturate with the sign of dy
                s = (dy >= 0) ? SLOPE_SAT : -SLOPE_SAT;
            end else begin
                s = (dy * ONE_Q) / dx;
                if (s > SLOPE_SAT) s = SLOPE_SAT;
                if (s < -SLOPE_SAT) s = -SLOPE_SAT;
            end
            b = y1 * ONE_Q - s * x1;
            if (b > ICPT_SAT) b = ICPT_SAT;
            if (b < -ICPT_SAT - 1) b = -ICPT_SAT - 1;
            // ties keep the earlier segment
            if (new_frame || mag_of(s) < mag_of(kept_slope)) begin
                kept_slope = s;
                kept_icpt  = b;
            end
            new_frame = 1'b0;
        end
        if (!r.last) return;

        if (r.cmd_a) base = 0;
        else if (r.cmd_b) base = cfg_duty_mid;
        else base = cfg_duty_low;

        s   = kept_slope;
        b   = kept_icpt;
        w   = cfg_width;
        mag = mag_of(s);
        div = MOTOR_DIVISOR;
        if (mag < longint'(cfg_max_slope) && mag > longint'(cfg_min_slope)) begin
            if (s > 0 && x_left_of(b, s, border_at(w, BORDER_POS_OUTER))) begin
                if (x_left_of(b, s, border_at(w, BORDER_POS_HARD))) begin
                    res.zone = ZONE_LEFT;        res.servo = SERVO_LEFT;        mul = FACTOR_HARD;
                end else if (x_left_of(b, s, border_at(w, BORDER_POS_SOFT))) begin
                    res.zone = ZONE_LITTLE_LEFT; res.servo = SERVO_LITTLE_LEFT; mul = FACTOR_SOFT;
                end else begin
                    res.zone = ZONE_LEFT_CORR;   res.servo = SERVO_LEFT_CORR;   mul = FACTOR_CORR;
                end
            end else if (s < 0 && x_right_of(b, s, border_at(w, BORDER_NEG_OUTER))) begin
                if (x_right_of(b, s, border_at(w, BORDER_NEG_HARD))) begin
                    res.zone = ZONE_RIGHT;        res.servo = SERVO_RIGHT;        mul = FACTOR_HARD;
                end else if (x_right_of(b, s, border_at(w, BORDER_NEG_SOFT))) begin
                    res.zone = ZONE_LITTLE_RIGHT; res.servo = SERVO_LITTLE_RIGHT; mul = FACTOR_SOFT;
                end else begin
                    res.zone = ZONE_RIGHT_CORR;   res.servo = SERVO_RIGHT_CORR;   mul = FACTOR_CORR;
                end
            end else begin
                res.zone = ZONE_FORWARD; res.servo = SERVO_FORWARD; mul = FACTOR_SOFT;
            end
            last_servo = res.servo;
            res.motor  = 13'(base * mul / div);
        end else begin
            // slope out of limits (zero slope included): hold the servo
            res.zone  = ZONE_HOLD;
            res.servo = last_servo;
            res.motor = 13'(base);
        end
        new_frame = 1'b1;
        steer_expect_q.push_back(res);
    endfunction

    function automatic seg_req_t make_req(input bit hs, input int sx, input int sy,
                                          input int ex, input int ey, input bit last,
                                          input bit a, input bit b);
        seg_req_t r;
        r.has_seg = hs;
        r.start_x = sx;
        r.start_y = sy;
        r.end_x   = ex;
        r.end_y   = ey;
        r.last    = last;
        r.cmd_a   = a;
        r.cmd_b   = b;
        return r;
    endfunction

    function automatic int clip_coord(input int v);
        if (v < 0) return 0;
        if (v > 4095) return 4095;
        return v;
    endfunction

    // Mostly segments near the frame so the zones get exercised; some noise,
    // some vertical ones, some full-range coordinates.
    function automatic seg_req_t random_item(input bit is_last);
        seg_req_t r;
        int pick, span, sx, sy, ddx, ddy;
        pick    = $urandom_range(0, 99);
        r.last  = is_last;
        r.cmd_a = ($urandom_range(0, 3) == 0);
        r.cmd_b = $urandom_range(0, 1);
        if (pick < 8) begin
            r.has_seg = $urandom_range(0, 1);
            r.start_x = $urandom_range(0, 4095);
            r.start_y = $urandom_range(0, 4095);
            r.end_x   = $urandom_range(0, 4095);
            r.end_y   = $urandom_range(0, 4095);
        end else if (pick < 12) begin
            r.has_seg = 1'b1;
            r.start_x = $urandom_range(0, 4095);
            r.end_x   = r.start_x;
            r.start_y = $urandom_range(0, 4095);
            r.end_y   = $urandom_range(0, 4095);
        end else begin
            span = int'(cfg_width) * 5 / 4 + 2;
            if (span > 4095) span = 4095;
            sx  = $urandom_range(0, span);
            sy  = $urandom_range(0, 127);
            ddx = $urandom_range(1, 300);
            ddy = $urandom_range(0, 600);
            if ($urandom_range(0, 1)) ddx = -ddx;
            if ($urandom_range(0, 1)) ddy = -ddy;
            r.has_seg = !(is_last && $urandom_range(0, 99) < 15);
            r.start_x = sx;
            r.start_y = sy;
            r.end_x   = clip_coord(sx + ddx);
            r.end_y   = clip_coord(sy + ddy);
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus tasks
    // ---------------------------------------------------------------

    // Offer one request at the falling edge, wait for the handshake, then
    // either keep tvalid up for the next request or drop it for a gap.
    task automatic send_request(input seg_req_t r);
        @(negedge aclk);
        s_tdata  = {r.end_y, r.end_x, r.start_y, r.start_x};
        s_tuser  = {r.cmd_b, r.cmd_a, r.has_seg};
        s_tlast  = r.last;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (s_tready !== 1'b1);
        predict_steering(r);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (gap_len) @(negedge aclk);
            // new burst: long stretches now and then, gaps over all latency phases
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 8);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: gap_len = $urandom_range(0, 3);
                5, 6, 7, 8:    gap_len = $urandom_range(4, 50);
                default:       gap_len = $urandom_range(51, 120);
            endcase
        end
    endtask

    task automatic send_random_frame();
        int n;
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++) send_request(random_item(i == n - 1));
    endtask

    // Register writes only with the block idle: all results back plus the
    // latency of any trailing request that gives no result.
    task automatic wait_block_idle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (steer_expect_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [25:0] data);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_addr  = addr;
        cfg_wdata = data;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (addr)
            REG_FRAME_WIDTH:  cfg_width     = data[11:0];
            REG_MAX_SLOPE:    cfg_max_slope = data;
            REG_MIN_SLOPE:    cfg_min_slope = data;
            REG_DUTY_CMD_LOW: cfg_duty_low  = data[11:0];
            REG_DUTY_CMD_MID: cfg_duty_mid  = data[11:0];
            default: ;  // unused index, no effect
        endcase
    endtask

    task automatic write_all_regs(input logic [11:0] w, input logic [25:0] smax,
                                  input logic [25:0] smin, input logic [11:0] dlo,
                                  input logic [11:0] dmid);
        write_reg(REG_FRAME_WIDTH, 26'(w));
        write_reg(REG_MAX_SLOPE, smax);
        write_reg(REG_MIN_SLOPE, smin);
        write_reg(REG_DUTY_CMD_LOW, 26'(dlo));
        write_reg(REG_DUTY_CMD_MID, 26'(dmid));
    endtask

    // Reset defaults: every zone, hold cases, vertical and saturated slopes,
    // ties, frames without segments, ignored requests, coordinate extremes.
    task automatic test_directed_defaults();
        send_request(make_req(0,    0,    0,    0,    0, 1, 0, 0)); // empty frame after reset
        send_request(make_req(1,    0,    0,  100,  100, 1, 0, 1)); // left
        send_request(make_req(1,  160,    0,  260,  100, 1, 0, 0)); // little left
        send_request(make_req(1,  250,    0,  350,  100, 1, 1, 0)); // left correction
        send_request(make_req(1,  310,    0,  410,  100, 1, 0, 1)); // forward, positive
        send_request(make_req(1,  300,  100,  200,  200, 1, 0, 0)); // right
        send_request(make_req(1,  150,    0,   50,  100, 1, 0, 0)); // little right
        send_request(make_req(1,  100,    0,    0,  100, 1, 1, 1)); // right corr, on border
        send_request(make_req(1,   10,    0,    0,   10, 1, 0, 0)); // forward, negative
        send_request(make_req(1,   50,   10,   50,  200, 1, 0, 0)); // vertical up
        send_request(make_req(1,   50,  200,   50,   10, 1, 0, 1)); // vertical down
        send_request(make_req(1,    0,   50,  100,   50, 1, 0, 0)); // zero slope
        send_request(make_req(1,    0,    0, 4095,    1, 1, 0, 0)); // below min
        send_request(make_req(1,    0,    0,    1, 4095, 1, 0, 0)); // saturates high
        send_request(make_req(1,    0, 4095,    1,    0, 1, 0, 0)); // saturates low
        // equal magnitudes: the first one stays
        send_request(make_req(1,    0,    0,  100,  100, 0, 0, 0));
        send_request(make_req(1,  300,  100,  200,  200, 1, 0, 0));
        send_request(make_req(1,  300,  100,  200,  200, 0, 0, 1));
        send_request(make_req(1,    0,    0,  100,  100, 1, 0, 1));
        // segment, then a frame end without one
        send_request(make_req(1,  160,    0,  260,  100, 0, 0, 0));
        send_request(make_req(0, 4095, 4095, 4095, 4095, 1, 0, 0));
        // ignored request, then an empty frame reusing the previous segment
        send_request(make_req(0, 4095, 4095, 4095, 4095, 0, 1, 1));
        send_request(make_req(0,    0,    0,    0,    0, 1, 0, 1));
        send_request(make_req(1, 4095, 4095,    0,    0, 1, 0, 0)); // corner to corner
        send_request(make_req(1,    0, 4095, 4095,    0, 1, 0, 0));
        wait_block_idle();
    endtask

    // Register extremes, plus writes to unused indexes.
    task automatic test_register_extremes();
        for (int k = 0; k < 7; k++) begin
            case (k)
                0: write_reg(REG_FRAME_WIDTH, 26'd1);
                1: write_all_regs(12'd4095, 26'h3FFFFFF, 26'd0, 12'd1250, 12'd1150);
                2: write_reg(REG_MAX_SLOPE, 26'd0);
                3: write_all_regs(12'd320, 26'h3FFFFFF, 26'h3FFFFFF, 12'd0, 12'd0);
                4: write_all_regs(12'd320, 26'h3FFFFFF, 26'd0, 12'd4095, 12'd4095);
                5: write_all_regs(12'd4095, 26'd262144, 26'd6554, 12'd0, 12'd4095);
                default: begin
                    write_reg(3'd5, 26'($urandom));
                    write_reg(3'd6, 26'($urandom));
                    write_reg(3'd7, 26'($urandom));
                    write_all_regs(RST_FRAME_WIDTH, RST_MAX_SLOPE, RST_MIN_SLOPE,
                                   RST_DUTY_CMD_LOW, RST_DUTY_CMD_MID);
                end
            endcase
            repeat (3) send_random_frame();
            wait_block_idle();
        end
    endtask

    // Random phases with random settings; one phase runs under a long
    // receiver hold-off so the block backs up into the sender.
    task automatic test_random_traffic();
        int start;
        logic [11:0] w;
        logic [25:0] smax, smin;
        for (int ph = 0; ph < 6; ph++) begin
            w    = ($urandom_range(0, 9) < 7) ? $urandom_range(64, 640)
                                              : $urandom_range(1, 4095);
            smax = ($urandom_range(0, 9) < 8) ? $urandom_range(1 << 16, 8 << 16)
                                              : 26'($urandom);
            smin = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 1 << 15)
                                              : 26'($urandom);
            write_all_regs(w, smax, smin, 12'($urandom), 12'($urandom));
            if (ph == 2) hold_req = 1'b1;
            start = items_sent;
            while (items_sent - start < 100) send_random_frame();
            wait_block_idle();
        end
    endtask

    // ---------------------------------------------------------------
    // Receiver: shifting stall rate, plus the long hold-off on request
    // ---------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (pattern_left == 0) begin
            pattern_left = $urandom_range(20, 200);
            case ($urandom_range(0, 3))
                0:       stall_pct = 0;
                1:       stall_pct = 20;
                2:       stall_pct = 50;
                default: stall_pct = 85;
            endcase
        end else begin
            pattern_left--;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready = 1'b0;
        end else begin
            m_tready = ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // ---------------------------------------------------------------
    // Result checker: oldest expectation against each accepted result
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (steer_expect_q.size() == 0) begin
                $display("%0t: result with none expected, got tdata %h", $time, m_tdata);
                errors++;
            end else begin
                exp_res = steer_expect_q.pop_front();
                if (m_tdata[11:0] !== exp_res.servo) begin
                    $display("%0t: servo_pulse expected %0d, got %0d",
                             $time, exp_res.servo, m_tdata[11:0]);
                    errors++;
                end
                if (m_tdata[24:12] !== exp_res.motor) begin
                    $display("%0t: motor_duty expected %0d, got %0d",
                             $time, exp_res.motor, m_tdata[24:12]);
                    errors++;
                end
                if (m_tdata[27:25] !== exp_res.zone) begin
                    $display("%0t: steer_zone expected %0d, got %0d",
                             $time, exp_res.zone, m_tdata[27:25]);
                    errors++;
                end
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        s_tlast    = 1'b0;
        m_tready   = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_addr   = '0;
        cfg_wdata  = '0;
        errors     = 0;
        items_sent = 0;
        cycle_count = 0;
        burst_left = 0;
        gap_len    = 0;
        hold_req   = 1'b0;
        hold_left  = 0;
        pattern_left = 0;
        stall_pct  = 0;
        // model at reset
        cfg_width     = RST_FRAME_WIDTH;
        cfg_max_slope = RST_MAX_SLOPE;
        cfg_min_slope = RST_MIN_SLOPE;
        cfg_duty_low  = RST_DUTY_CMD_LOW;
        cfg_duty_mid  = RST_DUTY_CMD_MID;
        kept_slope    = 0;
        kept_icpt     = 0;
        new_frame     = 1'b1;
        last_servo    = '0;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed_defaults();
        test_register_extremes();
        test_random_traffic();
        wait_block_idle();

        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== lane_segment_steering_decider.f =====
rtl/core/lssd_pkg.sv
rtl/core/lssd_div.sv
rtl/core/lssd_datapath.sv
rtl/core/lssd_ctrl.sv
rtl/core/lane_segment_steering_decider.sv
sim/tb_lane_segment_steering_decider.sv
